[rtl/core/slcd_pkg.sv]
package slcd_pkg;

  localparam int ENTRIES   = 64;
  localparam int MAX_COUNT = 8;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_COMMIT = 2'd1;
  localparam logic [1:0] MODE_INVAL  = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  // one directory entry as held in the tag memory
  typedef struct packed {
    logic [1:0]  drive;
    logic [31:0] sector;
    logic [31:0] stamp;
  } entry_t;

endpackage

[rtl/core/sector_lru_cache_directory_unit.sv]
// Channel  | Direction | Ports                                   | Beat
// input    | in        | in_valid in_stall in_mode in_drive      | one request
//          |           | in_lba in_count in_read_gen             |
// result   | out       | out_valid out_stall out_ok out_slot     | one sector or status
//          |           | out_generation out_last                 |
// One request at a time. A single entry scan unit reads one tag memory entry per cycle;
// a read scans once per sector to check residency, then once more per sector to stamp;
// a commit scans once per sector, with a victim search on a miss; an invalidate makes one
// scan pass; rejects go straight to the result beat.
// Synchronous active-low reset clears valid bits, stamp clock and generation at once.
// in_stall is high while a request is in flight; out_stall holds the result register.
module sector_lru_cache_directory_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_drive,
  input  logic [31:0] in_lba,
  input  logic [7:0]  in_count,
  input  logic [31:0] in_read_gen,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [5:0]  out_slot,
  output logic [31:0] out_generation,
  output logic        out_last
);

  localparam int IW = slcd_pkg::IDX_W;
  localparam int CW = slcd_pkg::CNT_W;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHECK = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_DEC   = 9'b000001000,
    ST_VICT  = 9'b000010000,
    ST_WRITE = 9'b000100000,
    ST_INVAL = 9'b001000000,
    ST_EMIT  = 9'b010000000,
    ST_WAIT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // tag memory and valid bits
  slcd_pkg::entry_t mem [slcd_pkg::ENTRIES];
  logic [slcd_pkg::ENTRIES-1:0] valid_r;
  slcd_pkg::entry_t rd_q;

  logic [1:0]  mode_r;
  logic [1:0]  drive_r;
  logic [31:0] lba_r;
  logic [7:0]  count_r;
  logic [7:0]  sec_r;          // sector offset being worked
  logic        phase_r;        // read: 0 = residency check, 1 = stamp pass
  logic [CW-1:0] scan_r;       // address issued this cycle (may equal ENTRIES at end)
  logic          rd_v_r;       // rd_q holds entry at rd_idx_r
  logic [IW-1:0] rd_idx_r;
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic          free_r;
  logic [IW-1:0] free_idx_r;
  logic [IW-1:0] lru_idx_r;
  logic [31:0]   lru_stamp_r;
  logic [IW-1:0] tgt_r;
  logic [31:0]   clock_r, gen_r;

  logic        ov_r, ook_r, olast_r;
  logic [5:0]  oslot_r;

  logic [31:0] sec_addr;
  assign sec_addr = lba_r + 32'(sec_r);

  logic [IW-1:0] scan_idx;
  assign scan_idx = scan_r[IW-1:0];
  logic scan_end;
  assign scan_end = (scan_r == CW'(slcd_pkg::ENTRIES));

  // a read is issued in every scanning state until the end address
  logic scan_issue;
  assign scan_issue = (state_r inside {ST_SCAN, ST_VICT, ST_INVAL}) && !scan_end;

  // compare unit over the registered read
  logic rd_valid_bit, rd_match, rd_in_range;
  assign rd_valid_bit = valid_r[rd_idx_r];
  assign rd_match     = rd_valid_bit && rd_q.drive == drive_r && rd_q.sector == sec_addr;
  assign rd_in_range  = rd_valid_bit && rd_q.drive == drive_r &&
                        ((rd_q.sector - lba_r) < 32'(count_r));

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_ok    = ook_r;
  assign out_slot  = oslot_r;
  assign out_generation = gen_r;
  assign out_last  = olast_r;

  logic accept_in;
  assign accept_in = in_valid && !in_stall;

  // memory read port
  always_ff @(posedge clk) begin
    if (!scan_end) rd_q <= mem[scan_idx];
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      clock_r <= '0;
      gen_r   <= '0;
      ov_r    <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      rd_v_r   <= scan_issue;
      rd_idx_r <= scan_idx;
      case (state_r)
        ST_IDLE: begin
          if (accept_in) begin
            mode_r  <= in_mode;
            drive_r <= in_drive;
            lba_r   <= in_lba;
            count_r <= in_count;
            sec_r   <= '0;
            phase_r <= 1'b0;
            scan_r  <= '0;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            lru_idx_r <= '0;
            if (in_count == 8'd0 || in_mode == slcd_pkg::MODE_RSVD ||
                (in_mode != slcd_pkg::MODE_INVAL &&
                 in_count > 8'(slcd_pkg::MAX_COUNT)) ||
                (in_mode == slcd_pkg::MODE_COMMIT && in_read_gen != gen_r)) begin
              ook_r <= 1'b0; oslot_r <= '0; olast_r <= 1'b1;
              state_r <= ST_EMIT;
            end else if (in_mode == slcd_pkg::MODE_INVAL) begin
              gen_r   <= gen_r + 32'd1;
              state_r <= ST_INVAL;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        // tag match scan: one entry a cycle
        ST_SCAN: begin
          if (!scan_end) begin
            scan_r <= scan_r + CW'(1);
          end
          if (rd_v_r && rd_match && !hit_r) begin
            hit_r <= 1'b1; hit_idx_r <= rd_idx_r;
          end
          if (scan_end && !rd_v_r) state_r <= ST_DEC;
        end
        ST_DEC: begin
          scan_r <= '0;
          if (mode_r == slcd_pkg::MODE_READ && !hit_r) begin
            ook_r <= 1'b0; oslot_r <= '0; olast_r <= 1'b1;
            state_r <= ST_EMIT;
          end else if (mode_r == slcd_pkg::MODE_READ && !phase_r) begin
            hit_r <= 1'b0;
            if (sec_r + 8'd1 == count_r) begin
              sec_r <= '0; phase_r <= 1'b1;
            end else begin
              sec_r <= sec_r + 8'd1;
            end
            state_r <= ST_SCAN;
          end else if (hit_r) begin
            tgt_r <= hit_idx_r;
            state_r <= ST_WRITE;
          end else begin
            free_r <= 1'b0;
            lru_idx_r <= '0;
            state_r <= ST_VICT;
          end
        end
        // victim search: first free, else lowest stamp
        ST_VICT: begin
          if (!scan_end) begin
            scan_r <= scan_r + CW'(1);
          end
          if (rd_v_r && !free_r) begin
            if (!rd_valid_bit) begin
              free_r <= 1'b1; free_idx_r <= rd_idx_r;
            end else if (rd_idx_r == '0 || rd_q.stamp < lru_stamp_r) begin
              lru_idx_r <= rd_idx_r; lru_stamp_r <= rd_q.stamp;
            end
          end
          if (scan_end && !rd_v_r) begin
            tgt_r <= free_r ? free_idx_r : lru_idx_r;
            valid_r[free_r ? free_idx_r : lru_idx_r] <= 1'b1;
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          clock_r <= clock_r + 32'd1;
          ook_r   <= 1'b1;
          oslot_r <= 6'(tgt_r);
          olast_r <= (sec_r + 8'd1 == count_r);
          state_r <= ST_EMIT;
        end
        ST_INVAL: begin
          if (!scan_end) begin
            scan_r <= scan_r + CW'(1);
          end
          if (rd_v_r && rd_in_range) valid_r[rd_idx_r] <= 1'b0;
          if (scan_end && !rd_v_r) begin
            ook_r <= 1'b1; oslot_r <= '0; olast_r <= 1'b1;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!ov_r || !out_stall) begin
            ov_r <= 1'b1;
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!out_stall) begin
            if (olast_r) begin
              state_r <= ST_IDLE;
            end else begin
              sec_r  <= sec_r + 8'd1;
              scan_r <= '0;
              hit_r  <= 1'b0;
              state_r <= ST_SCAN;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // tag memory write: the entry that the write step stamps
  always_ff @(posedge clk) begin
    if (state_r == ST_WRITE) begin
      mem[tgt_r] <= '{drive: drive_r, sector: sec_addr, stamp: clock_r + 32'd1};
    end
  end

  // results never overlap: a new one is loaded only once the previous beat left
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r && $stable(oslot_r) && $stable(olast_r))
    else $error("result overwritten while stalled");
  // block is busy whenever a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> in_stall)
    else $error("input taken while result pending");
  // generation changes only by an invalidate, by one
  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_r != $past(gen_r)) |-> (gen_r == $past(gen_r) + 32'd1) &&
      (state_r == ST_INVAL))
    else $error("generation step wrong");

endmodule

[tb/tb_sector_lru_cache_directory_unit.sv]
`timescale 1ns / 100ps

module tb_sector_lru_cache_directory_unit;

  localparam int CYCLE_LIMIT = 5000000;

  // one request beat as queued for the driver
  typedef struct {
    logic [1:0]  mode;
    logic [1:0]  drive;
    logic [31:0] lba;
    logic [7:0]  count;
    logic [31:0] read_gen;
    bit          fresh_gen;  // take read_gen from the live generation
    bit          drain;      // hold off until all results are back
  } req_t;

  // one expected result beat
  typedef struct {
    logic        ok;
    logic [5:0]  slot;
    logic [31:0] generation;
    logic        last;
  } res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [1:0]  in_drive;
  logic [31:0] in_lba;
  logic [7:0]  in_count;
  logic [31:0] in_read_gen;
  logic        out_valid;
  logic        out_stall;
  logic        out_ok;
  logic [5:0]  out_slot;
  logic [31:0] out_generation;
  logic        out_last;

  sector_lru_cache_directory_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_drive      (in_drive),
    .in_lba        (in_lba),
    .in_count      (in_count),
    .in_read_gen   (in_read_gen),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_slot      (out_slot),
    .out_generation(out_generation),
    .out_last      (out_last)
  );

  // directory shadow
  bit          dir_valid [slcd_pkg::ENTRIES];
  logic [1:0]  dir_drive [slcd_pkg::ENTRIES];
  logic [31:0] dir_sector[slcd_pkg::ENTRIES];
  logic [31:0] dir_stamp [slcd_pkg::ENTRIES];
  logic [31:0] stamp_now;
  logic [31:0] gen_now;

  req_t pend_q[$];
  res_t slot_q[$];
  req_t cur_req;
  int   gap_cnt;
  int   stall_cnt;
  bit   calm_in, calm_out;
  int   mismatches;
  int   cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int find_entry(logic [1:0] drv, logic [31:0] sec);
    for (int i = 0; i < slcd_pkg::ENTRIES; i++)
      if (dir_valid[i] && dir_drive[i] == drv && dir_sector[i] == sec) return i;
    return -1;
  endfunction

  function automatic int pick_victim();
    int lru;
    lru = 0;
    for (int i = 0; i < slcd_pkg::ENTRIES; i++) begin
      if (!dir_valid[i]) return i;
      if (dir_stamp[i] < dir_stamp[lru]) lru = i;
    end
    return lru;
  endfunction

  function automatic void push_res(logic ok, int slot, logic last);
    res_t r;
    r.ok = ok;
    r.slot = slot[5:0];
    r.generation = gen_now;
    r.last = last;
    slot_q.push_back(r);
  endfunction

  // apply one accepted request to the shadow and queue its results
  function automatic void predict_lookup(req_t q);
    int e;
    logic [31:0] sec;
    if (q.count == 8'd0 || q.mode == slcd_pkg::MODE_RSVD) begin
      push_res(1'b0, 0, 1'b1);
    end else if (q.mode == slcd_pkg::MODE_INVAL) begin
      gen_now++;
      for (int i = 0; i < slcd_pkg::ENTRIES; i++)
        if (dir_valid[i] && dir_drive[i] == q.drive &&
            (dir_sector[i] - q.lba) < {24'd0, q.count})
          dir_valid[i] = 0;
      push_res(1'b1, 0, 1'b1);
    end else if (q.count > slcd_pkg::MAX_COUNT) begin
      push_res(1'b0, 0, 1'b1);
    end else if (q.mode == slcd_pkg::MODE_READ) begin
      for (int s = 0; s < q.count; s++)
        if (find_entry(q.drive, q.lba + 32'(s)) < 0) begin
          push_res(1'b0, 0, 1'b1);
          return;
        end
      for (int s = 0; s < q.count; s++) begin
        e = find_entry(q.drive, q.lba + 32'(s));
        stamp_now++;
        dir_stamp[e] = stamp_now;
        push_res(1'b1, e, s + 1 == q.count);
      end
    end else if (q.read_gen != gen_now) begin
      push_res(1'b0, 0, 1'b1);
    end else begin
      for (int s = 0; s < q.count; s++) begin
        sec = q.lba + 32'(s);
        e = find_entry(q.drive, sec);
        if (e < 0) begin
          e = pick_victim();
          dir_valid[e] = 1;
          dir_drive[e] = q.drive;
          dir_sector[e] = sec;
        end
        stamp_now++;
        dir_stamp[e] = stamp_now;
        push_res(1'b1, e, s + 1 == q.count);
      end
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void add_req(logic [1:0] mode, logic [1:0] drv, logic [31:0] lba,
                                  logic [7:0] cnt, logic [31:0] rgen, bit fresh, bit drain);
    req_t q;
    q.mode = mode;
    q.drive = drv;
    q.lba = lba;
    q.count = cnt;
    q.read_gen = rgen;
    q.fresh_gen = fresh;
    q.drain = drain;
    pend_q.push_back(q);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      gap_cnt <= 0;
      calm_in <= 0;
    end else begin
      if ($urandom_range(0, 150) == 0) calm_in <= ~calm_in;
      if (in_valid && !in_stall) predict_lookup(cur_req);
      if (!(in_valid && in_stall)) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_valid <= 0;
        end else if (pend_q.size() > 0 && !(pend_q[0].drain && slot_q.size() > 0)) begin
          cur_req = pend_q.pop_front();
          if (cur_req.fresh_gen) cur_req.read_gen = gen_now;
          in_mode <= cur_req.mode;
          in_drive <= cur_req.drive;
          in_lba <= cur_req.lba;
          in_count <= cur_req.count;
          in_read_gen <= cur_req.read_gen;
          in_valid <= 1;
          gap_cnt <= calm_in ? 0 : gap_len();
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // result stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      stall_cnt <= 0;
      calm_out <= 0;
    end else begin
      if ($urandom_range(0, 150) == 0) calm_out <= ~calm_out;
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_stall <= 1;
      end else if (!calm_out && $urandom_range(0, 3) == 0) begin
        stall_cnt <= gap_len();
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    res_t x;
    if (rst_n && out_valid && !out_stall) begin
      if (slot_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: ok=%0d slot=%0d gen=%h last=%0d",
                   out_ok, out_slot, out_generation, out_last);
      end else begin
        x = slot_q.pop_front();
        if (out_ok !== x.ok || out_slot !== x.slot ||
            out_generation !== x.generation || out_last !== x.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ok=%0d slot=%0d gen=%h last=%0d, got ok=%0d slot=%0d gen=%h last=%0d",
                     x.ok, x.slot, x.generation, x.last,
                     out_ok, out_slot, out_generation, out_last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] bases[12];
    logic [31:0] lba;
    int r;
    rst_n = 0;
    in_valid = 0;
    in_mode = 0;
    in_drive = 0;
    in_lba = 0;
    in_count = 0;
    in_read_gen = 0;
    out_stall = 0;
    mismatches = 0;
    cycles = 0;
    stamp_now = 0;
    gen_now = 0;
    for (int i = 0; i < slcd_pkg::ENTRIES; i++) dir_valid[i] = 0;

    // directed: rejects, wrap, hit, miss, stale, invalidate
    add_req(slcd_pkg::MODE_READ, 2'd0, 32'h0, 8'd0, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_COMMIT, 2'd1, 32'h10, 8'd0, 32'd0, 1'b1, 1'b0);
    add_req(slcd_pkg::MODE_INVAL, 2'd2, 32'h10, 8'd0, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_RSVD, 2'd3, 32'hFFFF_FFFF, 8'd4, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_READ, 2'd0, 32'h0, 8'd9, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_COMMIT, 2'd0, 32'h0, 8'd255, 32'd0, 1'b1, 1'b0);
    add_req(slcd_pkg::MODE_READ, 2'd3, 32'hFFFF_FFFC, 8'd8, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_COMMIT, 2'd3, 32'hFFFF_FFFC, 8'd8, 32'd0, 1'b1, 1'b0);
    add_req(slcd_pkg::MODE_READ, 2'd3, 32'hFFFF_FFFC, 8'd8, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_READ, 2'd3, 32'hFFFF_FFFE, 8'd3, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_READ, 2'd2, 32'hFFFF_FFFE, 8'd3, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_COMMIT, 2'd0, 32'h0, 8'd1, 32'd0, 1'b1, 1'b0);
    add_req(slcd_pkg::MODE_READ, 2'd0, 32'h0, 8'd1, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_COMMIT, 2'd1, 32'h5, 8'd2, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_INVAL, 2'd3, 32'hFFFF_FFFF, 8'd2, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_READ, 2'd3, 32'hFFFF_FFFC, 8'd8, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_READ, 2'd3, 32'hFFFF_FFFC, 8'd3, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_COMMIT, 2'd1, 32'h5, 8'd2, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_INVAL, 2'd0, 32'h0, 8'd255, 32'd0, 1'b0, 1'b1);
    add_req(slcd_pkg::MODE_READ, 2'd0, 32'h0, 8'd1, 32'd0, 1'b0, 1'b0);
    add_req(slcd_pkg::MODE_INVAL, 2'd1, 32'hAAAA_5555, 8'd1, 32'h5555_AAAA, 1'b0, 1'b0);

    // random: mostly commit/read over a small sector pool so hits and evictions occur
    for (int i = 0; i < 12; i++) bases[i] = $urandom;
    bases[0] = 32'hFFFF_FFF8;
    bases[1] = 32'h0;
    for (int n = 0; n < 410; n++) begin
      lba = bases[$urandom_range(0, 11)] + 32'($urandom_range(0, 12));
      r = $urandom_range(0, 99);
      if (r < 40)
        add_req(slcd_pkg::MODE_COMMIT, 2'($urandom_range(0, 1)), lba,
                8'($urandom_range(1, slcd_pkg::MAX_COUNT)), 32'd0, 1'b1, n % 150 == 75);
      else if (r < 75)
        add_req(slcd_pkg::MODE_READ, 2'($urandom_range(0, 1)), lba,
                8'($urandom_range(1, slcd_pkg::MAX_COUNT)), 32'd0, 1'b0, 1'b0);
      else if (r < 83)
        add_req(slcd_pkg::MODE_INVAL, 2'($urandom_range(0, 3)), lba,
                8'($urandom_range(1, 16)), 32'd0, 1'b0, 1'b0);
      else if (r < 88)
        add_req(slcd_pkg::MODE_COMMIT, 2'($urandom_range(0, 3)), lba,
                8'($urandom_range(1, slcd_pkg::MAX_COUNT)), gen_now - 32'd1, 1'b0, 1'b0);
      else
        add_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom,
                8'($urandom_range(0, 255)), $urandom, 1'b0, 1'b0);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1;

    while (pend_q.size() > 0 || in_valid || slot_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && slot_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
